[src/pbu_pkg.sv]
// shared types, defaults and helpers for the paletted bit-packed unpacker
// no dependencies; used by paletted_bitpacked_unpacker

package pbu_pkg;

    // parameter defaults
    localparam int PALETTE_DEPTH_DEF     = 256;
    localparam int SECTION_ENTRIES_DEF   = 4096;
    localparam int INDIRECT_MAX_BITS_DEF = 8;

    // fixed field widths
    localparam int WORD_BITS   = 64;
    localparam int ID_BITS     = 32;
    localparam int EBITS_W     = 6;
    localparam int POS_W       = 12;
    localparam int AVAIL_W     = 7;
    localparam int BUF_W       = 128;
    localparam int S_TDATA_W   = 104;
    localparam int M_TDATA_W   = 48;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_PALETTE = 2'd1,
        OP_DATA    = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_UNPACK  = 3'b010,
        ST_UNIFORM = 3'b100
    } state_t;

    // low n bits set, saturating at the id width
    function automatic logic [ID_BITS-1:0] low_mask32(input logic [EBITS_W-1:0] n);
        logic [ID_BITS-1:0] m;
        if (n >= EBITS_W'(ID_BITS))
            m = '1;
        else
            m = (ID_BITS'(1) << n) - ID_BITS'(1);
        return m;
    endfunction

endpackage

[src/paletted_bitpacked_unpacker.sv]
// Palette items and non-uniform start items complete in the idle state; a uniform start
// passes through ST_UNIFORM to launch its result. ready is high only while idle.
// A data word is accepted in the idle state, then cut at one entry per cycle by a shared
// barrel shifter while the output does not stall (up to floor(64/bits) entries for palette
// words, up to ceil(63/bits)+1 for direct words) before the word closes back to idle.
// A cut entry passes through the lookup stage (palette read) and the output register.
// Reset clears sequencer, counts and pending bits; palette contents are not cleared.

module paletted_bitpacked_unpacker #(
    parameter int PALETTE_DEPTH     = pbu_pkg::PALETTE_DEPTH_DEF,
    parameter int SECTION_ENTRIES   = pbu_pkg::SECTION_ENTRIES_DEF,
    parameter int INDIRECT_MAX_BITS = pbu_pkg::INDIRECT_MAX_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // entry_bits[5:0], state_value[37:6], data_word[101:38], zero pad
    input  logic [pbu_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]                     s_axis_tuser,
    // final_word
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pos_x[3:0], pos_y[7:4], pos_z[11:8], state_id[43:12], zero pad
    output logic [pbu_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // uniform
    output logic                           m_axis_tuser,
    // run_end
    output logic                           m_axis_tlast
);

    localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);
    localparam int EIW    = $clog2(SECTION_ENTRIES + 1);
    localparam int IW     = (INDIRECT_MAX_BITS > ADDR_W) ? INDIRECT_MAX_BITS : ADDR_W;
    localparam int HW     = (IW > CNT_W) ? IW : CNT_W;

    // input fields
    pbu_pkg::opcode_t                  op;
    logic [pbu_pkg::EBITS_W-1:0]       in_bits;
    logic [pbu_pkg::ID_BITS-1:0]       in_sv;
    logic [pbu_pkg::WORD_BITS-1:0]     in_word;

    assign op      = pbu_pkg::opcode_t'(s_axis_tuser);
    assign in_bits = s_axis_tdata[5:0];
    assign in_sv   = s_axis_tdata[37:6];
    assign in_word = s_axis_tdata[101:38];

    // sequencer state
    pbu_pkg::state_t                   state_reg, state_next;
    logic [pbu_pkg::EBITS_W-1:0]       bits_reg, bits_next;
    logic [CNT_W-1:0]                  pcount_reg, pcount_next;
    logic [EIW-1:0]                    index_reg, index_next;
    logic [pbu_pkg::WORD_BITS-1:0]     pend_reg, pend_next;
    logic [pbu_pkg::EBITS_W-1:0]       pend_cnt_reg, pend_cnt_next;
    logic [pbu_pkg::BUF_W-1:0]         buf_reg, buf_next;
    logic [pbu_pkg::AVAIL_W-1:0]       avail_reg, avail_next;
    logic                              fin_reg, fin_next;

    // lookup stage
    logic                              mv_reg, mv_next;
    logic [pbu_pkg::POS_W-1:0]         mpos_reg, mpos_next;
    logic [pbu_pkg::ID_BITS-1:0]       mraw_reg, mraw_next;
    logic                              mpal_reg, mpal_next;
    logic                              mhit_reg, mhit_next;
    logic                              muni_reg, muni_next;
    logic                              mlast_reg, mlast_next;

    // output register
    logic                              ov_reg, ov_next;
    logic [pbu_pkg::M_TDATA_W-1:0]     odata_reg, odata_next;
    logic                              ouni_reg, ouni_next;
    logic                              olast_reg, olast_next;

    // palette memory
    logic [pbu_pkg::ID_BITS-1:0]       pal_mem [PALETTE_DEPTH];
    logic [pbu_pkg::ID_BITS-1:0]       rd_data_reg;

    logic                              accept;
    logic                              out_free, m_adv, m_free;
    logic                              direct, full, fin_partial, have_entry, fire;
    logic [pbu_pkg::BUF_W-1:0]         shifted;
    logic [pbu_pkg::ID_BITS-1:0]       entry_val;
    logic [IW-1:0]                     idx_w;
    logic [ADDR_W-1:0]                 rd_addr;
    logic                              hit;
    logic [pbu_pkg::AVAIL_W-1:0]       avail_after;
    logic [EIW-1:0]                    index_inc;
    logic                              more_after;
    logic                              wr_en;
    logic [pbu_pkg::ID_BITS-1:0]       out_id;

    assign s_axis_tready = (state_reg == pbu_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign out_free = !ov_reg || m_axis_tready;
    assign m_adv    = mv_reg && out_free;
    assign m_free   = !mv_reg || m_adv;

    // entry cutting: shared right shifter over the bit buffer
    assign direct     = (bits_reg > pbu_pkg::EBITS_W'(INDIRECT_MAX_BITS));
    assign full       = (index_reg >= EIW'(SECTION_ENTRIES));
    assign fin_partial = direct && fin_reg && (avail_reg != '0);
    assign have_entry = !full &&
                        ((avail_reg >= {1'b0, bits_reg}) || fin_partial);
    assign fire       = (state_reg == pbu_pkg::ST_UNPACK) && have_entry && m_free;
    assign shifted    = buf_reg >> bits_reg;
    assign entry_val  = buf_reg[pbu_pkg::ID_BITS-1:0] & pbu_pkg::low_mask32(bits_reg);
    assign idx_w      = IW'(entry_val[INDIRECT_MAX_BITS-1:0]);
    assign rd_addr    = idx_w[ADDR_W-1:0];
    // compare at a width that holds both the index and a full palette count
    assign hit        = (HW'(idx_w) < HW'(pcount_reg));
    assign avail_after = (avail_reg >= {1'b0, bits_reg}) ?
                         (avail_reg - {1'b0, bits_reg}) : '0;
    assign index_inc  = index_reg + EIW'(1);
    // whether this item cuts another entry after the current one
    assign more_after = (index_inc < EIW'(SECTION_ENTRIES)) &&
                        ((avail_after >= {1'b0, bits_reg}) ||
                         (direct && fin_reg && (avail_after != '0)));

    assign wr_en = accept && (op == pbu_pkg::OP_PALETTE) &&
                   (pcount_reg < CNT_W'(PALETTE_DEPTH));

    always_comb
    begin
        state_next    = state_reg;
        bits_next     = bits_reg;
        pcount_next   = pcount_reg;
        index_next    = index_reg;
        pend_next     = pend_reg;
        pend_cnt_next = pend_cnt_reg;
        buf_next      = buf_reg;
        avail_next    = avail_reg;
        fin_next      = fin_reg;

        mv_next    = mv_reg && !m_adv;
        mpos_next  = mpos_reg;
        mraw_next  = mraw_reg;
        mpal_next  = mpal_reg;
        mhit_next  = mhit_reg;
        muni_next  = muni_reg;
        mlast_next = mlast_reg;

        case (state_reg)
            pbu_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        pbu_pkg::OP_START:
                        begin
                            bits_next     = in_bits;
                            pcount_next   = '0;
                            index_next    = '0;
                            pend_next     = '0;
                            pend_cnt_next = '0;
                            if (in_bits == '0)
                            begin
                                index_next = EIW'(SECTION_ENTRIES);
                                buf_next   = pbu_pkg::BUF_W'(in_sv);
                                state_next = pbu_pkg::ST_UNIFORM;
                            end
                        end
                        pbu_pkg::OP_PALETTE:
                        begin
                            if (wr_en)
                                pcount_next = pcount_reg + CNT_W'(1);
                        end
                        pbu_pkg::OP_DATA:
                        begin
                            if ((bits_reg != '0) && !full)
                            begin
                                // leftover bits of the last word sit below the new one
                                buf_next   = pbu_pkg::BUF_W'(pend_reg) |
                                             (pbu_pkg::BUF_W'(in_word) << pend_cnt_reg);
                                avail_next = pbu_pkg::AVAIL_W'(pbu_pkg::WORD_BITS) +
                                             pbu_pkg::AVAIL_W'(pend_cnt_reg);
                                fin_next   = s_axis_tlast;
                                state_next = pbu_pkg::ST_UNPACK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            pbu_pkg::ST_UNPACK:
            begin
                if (!have_entry)
                begin
                    // close the word: keep a direct remainder unless the section ends
                    if (fin_reg || full || !direct)
                    begin
                        pend_next     = '0;
                        pend_cnt_next = '0;
                    end
                    else
                    begin
                        pend_next     = buf_reg[pbu_pkg::WORD_BITS-1:0];
                        pend_cnt_next = avail_reg[pbu_pkg::EBITS_W-1:0];
                    end
                    if (fin_reg)
                        index_next = EIW'(SECTION_ENTRIES);
                    state_next = pbu_pkg::ST_IDLE;
                end
                else if (fire)
                begin
                    mv_next    = 1'b1;
                    mpos_next  = pbu_pkg::POS_W'(index_reg);
                    mraw_next  = entry_val;
                    mpal_next  = !direct;
                    mhit_next  = hit;
                    muni_next  = 1'b0;
                    mlast_next = !more_after;
                    index_next = index_inc;
                    buf_next   = shifted;
                    avail_next = avail_after;
                end
            end
            pbu_pkg::ST_UNIFORM:
            begin
                if (m_free)
                begin
                    mv_next    = 1'b1;
                    mpos_next  = '0;
                    mraw_next  = buf_reg[pbu_pkg::ID_BITS-1:0];
                    mpal_next  = 1'b0;
                    mhit_next  = 1'b0;
                    muni_next  = 1'b1;
                    mlast_next = 1'b1;
                    state_next = pbu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pbu_pkg::ST_IDLE;
            end
        endcase
    end

    // out-of-range palette indices give zero
    assign out_id = mpal_reg ? (mhit_reg ? rd_data_reg : '0) : mraw_reg;

    always_comb
    begin
        ov_next    = ov_reg && !m_axis_tready;
        odata_next = odata_reg;
        ouni_next  = ouni_reg;
        olast_next = olast_reg;
        if (m_adv)
        begin
            ov_next    = 1'b1;
            odata_next = {4'b0000, out_id, mpos_reg[11:8], mpos_reg[7:4], mpos_reg[3:0]};
            ouni_next  = muni_reg;
            olast_next = mlast_reg;
        end
    end

    // pos fields: x from index bits 3..0, y from 11..8, z from 7..4
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {odata_reg[47:12], odata_reg[7:4], odata_reg[11:8],
                            odata_reg[3:0]};
    assign m_axis_tuser  = ouni_reg;
    assign m_axis_tlast  = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pbu_pkg::ST_IDLE;
            bits_reg     <= '0;
            pcount_reg   <= '0;
            index_reg    <= '0;
            pend_reg     <= '0;
            pend_cnt_reg <= '0;
            fin_reg      <= 1'b0;
            mv_reg       <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bits_reg     <= bits_next;
            pcount_reg   <= pcount_next;
            index_reg    <= index_next;
            pend_reg     <= pend_next;
            pend_cnt_reg <= pend_cnt_next;
            fin_reg      <= fin_next;
            mv_reg       <= mv_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg   <= buf_next;
        avail_reg <= avail_next;
        mpos_reg  <= mpos_next;
        mraw_reg  <= mraw_next;
        mpal_reg  <= mpal_next;
        mhit_reg  <= mhit_next;
        muni_reg  <= muni_next;
        mlast_reg <= mlast_next;
        odata_reg <= odata_next;
        ouni_reg  <= ouni_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            pal_mem[pcount_reg[ADDR_W-1:0]] <= in_sv;
        if (fire && !direct)
            rd_data_reg <= pal_mem[rd_addr];
    end

endmodule
